FILE: rtl/lpb_pkg.sv
// Shared constants, request and status codes, and frame-table command types.
`timescale 1ns / 1ps

package lpb_pkg;

   localparam int POOL_FRAMES_DEF  = 16;
   localparam int PAGE_ID_BITS_DEF = 20;
   localparam int PIN_W            = 8;
   localparam int META_W           = PIN_W + 1;
   localparam int DISK_W           = 21;

   localparam logic [2:0] REQ_FETCH  = 3'd0;
   localparam logic [2:0] REQ_UNPIN  = 3'd1;
   localparam logic [2:0] REQ_FLUSH  = 3'd2;
   localparam logic [2:0] REQ_NEW    = 3'd3;
   localparam logic [2:0] REQ_DELETE = 3'd4;
   localparam logic [2:0] REQ_DIRTY  = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BEYOND  = 2'd1;
   localparam logic [1:0] ST_NOTRES  = 2'd2;
   localparam logic [1:0] ST_NOALLOC = 2'd3;

   localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

   typedef enum logic [1:0] {
      TBL_NONE,
      TBL_TOUCH,
      TBL_INSERT,
      TBL_FREE
   } tbl_op_type;

   typedef struct packed {
      tbl_op_type op;
      logic       set_tag;
   } tbl_cmd_type;

endpackage

FILE: rtl/lpb_meta_ram.sv
// Synchronous single-port-write, single-port-read memory for per-frame dirty and pin state.
`timescale 1ns / 1ps

module lpb_meta_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lpb_frame_table.sv
// Frame lanes holding valid bits, page tags and LRU ranks, with match and rank update logic.
`timescale 1ns / 1ps

module lpb_frame_table #(
   parameter int POOL_FRAMES  = 16,
   parameter int PAGE_ID_BITS = 20,
   parameter int FW           = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [PAGE_ID_BITS-1:0]       lookup_id,
   output logic [POOL_FRAMES-1:0]        hit_vec,
   output logic [POOL_FRAMES-1:0]        valid_vec,
   output logic [POOL_FRAMES-1:0]        oldest_vec,
   input  logic                          upd_en,
   input  lpb_pkg::tbl_cmd_type          upd_cmd,
   input  logic [FW-1:0]                 upd_frame,
   input  logic [PAGE_ID_BITS-1:0]       upd_tag,
   output logic [PAGE_ID_BITS-1:0]       tag_rd
);

   import lpb_pkg::*;

   logic [POOL_FRAMES-1:0]  valid_ff;
   logic [FW-1:0]           rank_ff [POOL_FRAMES];
   logic [PAGE_ID_BITS-1:0] tag_ff  [POOL_FRAMES];
   logic [FW-1:0]           sel_rank;

   assign sel_rank = rank_ff[upd_frame];
   assign tag_rd   = tag_ff[upd_frame];
   assign valid_vec = valid_ff;

   always_comb begin
      for (int i = 0; i < POOL_FRAMES; i++) begin
         hit_vec[i]    = valid_ff[i] && (tag_ff[i] == lookup_id);
         oldest_vec[i] = rank_ff[i] == FW'(POOL_FRAMES - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < POOL_FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (upd_en) begin
         for (int i = 0; i < POOL_FRAMES; i++) begin
            if (valid_ff[i] && (FW'(i) != upd_frame)) begin
               unique case (upd_cmd.op)
                  TBL_TOUCH: begin
                     if (rank_ff[i] < sel_rank) rank_ff[i] <= rank_ff[i] + 1'b1;
                  end
                  TBL_INSERT: begin
                     rank_ff[i] <= rank_ff[i] + 1'b1;
                  end
                  TBL_FREE: begin
                     if (rank_ff[i] > sel_rank) rank_ff[i] <= rank_ff[i] - 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         unique case (upd_cmd.op)
            TBL_TOUCH: begin
               rank_ff[upd_frame] <= '0;
            end
            TBL_INSERT: begin
               rank_ff[upd_frame]  <= '0;
               valid_ff[upd_frame] <= 1'b1;
            end
            TBL_FREE: begin
               rank_ff[upd_frame]  <= '0;
               valid_ff[upd_frame] <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (upd_en && upd_cmd.set_tag) begin
         tag_ff[upd_frame] <= upd_tag;
      end
   end

endmodule

FILE: rtl/lru_page_buffer_pool.sv
// A request taken in idle passes through three states, match, select/read and execute;
// the response is registered when execute fires, which waits while an earlier one is unaccepted.
// Requests are taken only in idle, serializing them through frame lanes and metadata memory.
// A finished response waits in the output register while the next request is taken.
// Reset is synchronous: all frames become free with zero pins, clean, and rank zero.
`timescale 1ns / 1ps

module lru_page_buffer_pool #(
   parameter int POOL_FRAMES  = lpb_pkg::POOL_FRAMES_DEF,
   parameter int PAGE_ID_BITS = lpb_pkg::PAGE_ID_BITS_DEF,
   parameter int FW           = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_type,
   input  logic [PAGE_ID_BITS-1:0]     req_page_id,
   input  logic [lpb_pkg::DISK_W-1:0]  req_disk_page_count,
   input  logic                        req_alloc_ok,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_hit,
   output logic [FW-1:0]               rsp_frame,
   output logic                        rsp_load_from_disk,
   output logic                        rsp_zero_fill,
   output logic                        rsp_write_back,
   output logic [PAGE_ID_BITS-1:0]     rsp_write_back_page,
   output logic                        rsp_release_on_disk,
   output logic [lpb_pkg::PIN_W-1:0]   rsp_pin_count_out
);

   import lpb_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_MATCH, S_SELECT, S_EXEC} state_type;

   state_type               state_ff;
   logic [2:0]              type_ff;
   logic [PAGE_ID_BITS-1:0] pid_ff;
   logic [DISK_W-1:0]       disk_ff;
   logic                    aok_ff;
   logic [POOL_FRAMES-1:0]  hit_vec_ff, free_vec_ff, old_vec_ff;
   logic [FW-1:0]           target_ff, target_in;
   logic                    found_ff, found_in;
   logic                    any_free_ff, any_free_in;

   logic [POOL_FRAMES-1:0]  hit_vec, valid_vec, oldest_vec;
   logic [PAGE_ID_BITS-1:0] tag_rd;
   logic [META_W-1:0]       rd_data;

   logic                    rsp_valid_ff;
   logic [1:0]              status_ff, status_in;
   logic                    hit_ff, hit_in;
   logic [FW-1:0]           frame_ff, frame_in;
   logic                    load_ff, load_in, zero_ff, zero_in, wb_ff, wb_in, rel_ff, rel_in;
   logic [PAGE_ID_BITS-1:0] wbp_ff, wbp_in;
   logic [PIN_W-1:0]        pins_ff, pins_in;

   logic                    exec_fire;
   logic                    mem_we;
   logic [META_W-1:0]       mem_wd;
   tbl_cmd_type             cmd;
   logic                    cur_dirty;
   logic [PIN_W-1:0]        cur_pins;

   assign req_ready = (state_ff == S_IDLE);
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   lpb_frame_table #(
      .POOL_FRAMES (POOL_FRAMES),
      .PAGE_ID_BITS(PAGE_ID_BITS),
      .FW          (FW)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .lookup_id (pid_ff),
      .hit_vec   (hit_vec),
      .valid_vec (valid_vec),
      .oldest_vec(oldest_vec),
      .upd_en    (exec_fire),
      .upd_cmd   (cmd),
      .upd_frame (target_ff),
      .upd_tag   (pid_ff),
      .tag_rd    (tag_rd)
   );

   lpb_meta_ram #(
      .DEPTH(POOL_FRAMES),
      .AW   (FW),
      .DW   (META_W)
   ) u_meta (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(target_ff),
      .wr_data(mem_wd),
      .rd_en  (state_ff == S_SELECT),
      .rd_addr(target_in),
      .rd_data(rd_data)
   );

   always_comb begin
      logic [FW-1:0] hit_idx, free_idx, old_idx;
      hit_idx  = '0;
      free_idx = '0;
      old_idx  = '0;
      for (int i = POOL_FRAMES - 1; i >= 0; i--) begin
         if (hit_vec_ff[i])  hit_idx  = FW'(i);
         if (free_vec_ff[i]) free_idx = FW'(i);
         if (old_vec_ff[i])  old_idx  = FW'(i);
      end
      found_in    = |hit_vec_ff;
      any_free_in = |free_vec_ff;
      priority if (found_in)    target_in = hit_idx;
      else if (any_free_in)     target_in = free_idx;
      else                      target_in = old_idx;
   end

   always_comb begin
      logic [PIN_W-1:0] np;
      logic             place;
      np        = '0;
      place     = 1'b0;
      cur_dirty = valid_vec[target_ff] && rd_data[META_W-1];
      cur_pins  = valid_vec[target_ff] ? rd_data[PIN_W-1:0] : '0;
      status_in = ST_OK;
      hit_in    = 1'b0;
      frame_in  = '0;
      load_in   = 1'b0;
      zero_in   = 1'b0;
      wb_in     = 1'b0;
      wbp_in    = '0;
      rel_in    = 1'b0;
      pins_in   = '0;
      mem_we    = 1'b0;
      mem_wd    = '0;
      cmd.op      = TBL_NONE;
      cmd.set_tag = 1'b0;
      unique case (type_ff)
         REQ_FETCH: begin
            if (32'(pid_ff) >= 32'(disk_ff)) begin
               status_in = ST_BEYOND;
            end else if (found_ff) begin
               hit_in = 1'b1;
               np     = (cur_pins == PIN_MAX) ? cur_pins : cur_pins + 1'b1;
               mem_wd = {cur_dirty, np};
               cmd.op = TBL_TOUCH;
            end else begin
               place   = 1'b1;
               np      = PIN_W'(1);
               load_in = 1'b1;
            end
            if (32'(pid_ff) < 32'(disk_ff)) begin
               mem_we   = 1'b1;
               frame_in = target_ff;
               pins_in  = np;
               if (place) mem_wd = {1'b0, np};
            end
         end
         REQ_UNPIN, REQ_FLUSH: begin
            if (!found_ff) begin
               status_in = ST_NOTRES;
            end else begin
               hit_in   = 1'b1;
               wb_in    = cur_dirty;
               wbp_in   = cur_dirty ? tag_rd : '0;
               np       = (type_ff == REQ_UNPIN && cur_pins != '0) ? cur_pins - 1'b1 : cur_pins;
               mem_we   = 1'b1;
               mem_wd   = {1'b0, np};
               frame_in = target_ff;
               pins_in  = np;
            end
         end
         REQ_NEW: begin
            if (!aok_ff) begin
               status_in = ST_NOALLOC;
            end else begin
               if (found_ff) begin
                  hit_in = 1'b1;
                  cmd.op = TBL_TOUCH;
               end else begin
                  place = 1'b1;
               end
               zero_in  = 1'b1;
               mem_we   = 1'b1;
               mem_wd   = {1'b0, PIN_W'(1)};
               frame_in = target_ff;
               pins_in  = PIN_W'(1);
            end
         end
         REQ_DELETE: begin
            rel_in = 1'b1;
            if (found_ff) begin
               hit_in = 1'b1;
               wb_in  = cur_dirty;
               wbp_in = cur_dirty ? tag_rd : '0;
               cmd.op = TBL_FREE;
            end
         end
         REQ_DIRTY: begin
            if (!found_ff) begin
               status_in = ST_NOTRES;
            end else begin
               hit_in   = 1'b1;
               mem_we   = 1'b1;
               mem_wd   = {1'b1, cur_pins};
               frame_in = target_ff;
               pins_in  = cur_pins;
            end
         end
         default: begin
         end
      endcase
      if (place) begin
         cmd.set_tag = 1'b1;
         if (any_free_ff) begin
            cmd.op = TBL_INSERT;
         end else begin
            cmd.op = TBL_TOUCH;
            wb_in  = cur_dirty;
            wbp_in = cur_dirty ? tag_rd : '0;
         end
      end
      if (!exec_fire) begin
         mem_we  = 1'b0;
         cmd.op  = TBL_NONE;
         cmd.set_tag = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_MATCH;
            end
            S_MATCH:  state_ff <= S_SELECT;
            S_SELECT: state_ff <= S_EXEC;
            S_EXEC: begin
               if (exec_fire) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         type_ff <= req_type;
         pid_ff  <= req_page_id;
         disk_ff <= req_disk_page_count;
         aok_ff  <= req_alloc_ok;
      end
      if (state_ff == S_MATCH) begin
         hit_vec_ff  <= hit_vec;
         free_vec_ff <= ~valid_vec;
         old_vec_ff  <= oldest_vec;
      end
      if (state_ff == S_SELECT) begin
         target_ff   <= target_in;
         found_ff    <= found_in;
         any_free_ff <= any_free_in;
      end
      if (exec_fire) begin
         status_ff <= status_in;
         hit_ff    <= hit_in;
         frame_ff  <= frame_in;
         load_ff   <= load_in;
         zero_ff   <= zero_in;
         wb_ff     <= wb_in;
         wbp_ff    <= wbp_in;
         rel_ff    <= rel_in;
         pins_ff   <= pins_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_frame           = frame_ff;
   assign rsp_load_from_disk  = load_ff;
   assign rsp_zero_fill       = zero_ff;
   assign rsp_write_back      = wb_ff;
   assign rsp_write_back_page = wbp_ff;
   assign rsp_release_on_disk = rel_ff;
   assign rsp_pin_count_out   = pins_ff;

endmodule

FILE: rtl/lpb_checker.sv
// Port-level assertions for the buffer pool and the bind that attaches them.
`timescale 1ns / 1ps

module lpb_checker #(
   parameter int POOL_FRAMES  = lpb_pkg::POOL_FRAMES_DEF,
   parameter int PAGE_ID_BITS = lpb_pkg::PAGE_ID_BITS_DEF,
   parameter int FW           = 4
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic                        rsp_hit,
   input logic [FW-1:0]               rsp_frame,
   input logic                        rsp_load_from_disk,
   input logic                        rsp_zero_fill,
   input logic                        rsp_write_back,
   input logic [PAGE_ID_BITS-1:0]     rsp_write_back_page,
   input logic [lpb_pkg::PIN_W-1:0]   rsp_pin_count_out
);

   import lpb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame) && $stable(rsp_status))
      else $error("Response changed while stalled.");

   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         !rsp_load_from_disk && !rsp_zero_fill && !rsp_write_back)
      else $error("Failed request reported an action.");

   a_wb_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_back |-> rsp_write_back_page == '0)
      else $error("Write-back page set without write-back.");

   a_load_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_from_disk |-> !rsp_hit && rsp_pin_count_out == PIN_W'(1))
      else $error("Load reported on a hit or with wrong pin count.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Second request taken while one is in work.");

endmodule

bind lru_page_buffer_pool lpb_checker #(
   .POOL_FRAMES (POOL_FRAMES),
   .PAGE_ID_BITS(PAGE_ID_BITS),
   .FW          (FW)
) u_lpb_checker (.*);
